// File: hdl/sss_pkg.sv
// ---------------------------------------------------------------------------
// sss_pkg - shared definitions for the sorted set store
// Capacity, derived widths, operation and status codes, cell control type.
// ---------------------------------------------------------------------------
package sss_pkg;

	localparam int SET_CAPACITY = 256;
	localparam int ID_W         = 31;
	localparam int SIZE_W       = 9;
	localparam int CNT_W        = $clog2(SET_CAPACITY + 1);

	// hit reduction: registered OR per group, then one final OR
	localparam int GRP_SIZE = 16;
	localparam int NGRP     = (SET_CAPACITY + GRP_SIZE - 1) / GRP_SIZE;

	localparam logic [1:0] FN_QUERY  = 2'd0;
	localparam logic [1:0] FN_INSERT = 2'd1;
	localparam logic [1:0] FN_DELETE = 2'd2;

	localparam logic [1:0] ST_DONE      = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;

	typedef struct packed {
		logic cmp;  // capture equality flag
		logic ins;  // shift right toward the tail, open slot for key
		logic del;  // shift left over the first matching entry
	} cell_ctl_t;

endpackage

// File: hdl/sorted_set_store.sv
// ---------------------------------------------------------------------------
// sorted_set_store - ascending sorted multiset of 31-bit object numbers
// Query, insert (after equal entries) and delete (one match) on a register
// chain of SET_CAPACITY cells.
// ---------------------------------------------------------------------------
// Usage: raise start with func and object_id while busy is low; that edge
// takes the transfer. Every operation returns exactly one result, shown for
// a single cycle with done high; the receiver cannot stall it, so sample it
// then. Busy stays high until the operation completes, so a new start is not
// taken before done, but the next start can be taken in the cycle done is
// high. Each operation runs the sequence compare, reduce the per-cell match
// flags through a registered OR tree, then shift the chain: a delete may
// only move entries once membership is known.
// func 3 behaves as a query. An insert into a full set returns status full,
// a delete of an absent number returns not found; neither changes the set.
// No clearing pass is needed after reset: slots beyond the count are
// never read.
// ---------------------------------------------------------------------------
module sorted_set_store (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [1:0]                func,
	input  logic [sss_pkg::ID_W-1:0]  object_id,
	output logic                      done,
	output logic                      member,
	output logic [1:0]                status,
	output logic [sss_pkg::SIZE_W-1:0] set_size
);

	localparam int CAP   = sss_pkg::SET_CAPACITY;
	localparam int CNT_W = sss_pkg::CNT_W;
	localparam int ID_W  = sss_pkg::ID_W;

	// sequencer phases
	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_CMP  = 2'd1;  // cells capture equality flags
	localparam logic [1:0] PH_RED  = 2'd2;  // group ORs register
	localparam logic [1:0] PH_UPD  = 2'd3;  // membership known, chain shifts

	logic [1:0]       phase_q;
	logic [1:0]       func_q;
	logic [ID_W-1:0]  key_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_nxt;

	logic                    done_q;
	logic                    member_q;
	logic [1:0]              status_q;
	logic [sss_pkg::SIZE_W-1:0] size_q;
	logic [1:0]              status_nxt;

	logic                    take;
	logic                    full;
	logic                    hit_any;
	sss_pkg::cell_ctl_t      ctl;

	logic [ID_W-1:0] ent  [CAP];
	logic [CAP-1:0]  gtx;
	logic [CAP-1:0]  hits;

	assign busy = (phase_q != PH_IDLE);
	assign take = start && !busy;
	assign full = (count_q == CNT_W'(CAP));

	// cell control for the current phase
	always_comb begin
		ctl.cmp = (phase_q == PH_CMP);
		ctl.ins = (phase_q == PH_UPD) && (func_q == sss_pkg::FN_INSERT) && !full;
		ctl.del = (phase_q == PH_UPD) && (func_q == sss_pkg::FN_DELETE) && hit_any;
	end

	// next count and status; func 3 falls to the query arm
	always_comb begin
		count_nxt  = count_q;
		status_nxt = sss_pkg::ST_DONE;
		case (func_q)
			sss_pkg::FN_INSERT: begin
				if (full) begin
					status_nxt = sss_pkg::ST_FULL;
				end else begin
					count_nxt = count_q + CNT_W'(1);
				end
			end
			sss_pkg::FN_DELETE: begin
				if (hit_any) begin
					count_nxt = count_q - CNT_W'(1);
				end else begin
					status_nxt = sss_pkg::ST_NOT_FOUND;
				end
			end
			default: begin
				count_nxt  = count_q;
				status_nxt = sss_pkg::ST_DONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			// result strobe rises in the cycle after the update phase
			done_q <= (phase_q == PH_UPD);
			case (phase_q)
				PH_IDLE: begin
					if (take) begin
						phase_q <= PH_CMP;
					end
				end
				PH_CMP: begin
					phase_q <= PH_RED;
				end
				PH_RED: begin
					phase_q <= PH_UPD;
				end
				PH_UPD: begin
					phase_q <= PH_IDLE;
					count_q <= count_nxt;
				end
				default: begin
					phase_q <= PH_IDLE;
				end
			endcase
		end
	end

	// transfer payload and result registers
	always_ff @(posedge clk) begin
		if (take) begin
			func_q <= func;
			key_q  <= object_id;
		end
		if (phase_q == PH_UPD) begin
			member_q <= hit_any;
			status_q <= status_nxt;
			size_q   <= sss_pkg::SIZE_W'(count_nxt);
		end
	end

	// the chain: slot 0 holds the smallest entry
	for (genvar i = 0; i < CAP; i++) begin : g_cell
		logic            valid_i;
		logic            left_gtx_i;
		logic [ID_W-1:0] left_ent_i;
		logic [ID_W-1:0] right_ent_i;

		assign valid_i = (CNT_W'(i) < count_q);

		if (i == 0) begin : g_head
			assign left_gtx_i = 1'b0;
			assign left_ent_i = key_q;
		end else begin : g_mid
			assign left_gtx_i = gtx[i-1];
			assign left_ent_i = ent[i-1];
		end

		if (i == CAP - 1) begin : g_tail
			assign right_ent_i = ent[i];
		end else begin : g_body
			assign right_ent_i = ent[i+1];
		end

		sss_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.key         (key_q),
			.valid       (valid_i),
			.left_gtx    (left_gtx_i),
			.left_entry  (left_ent_i),
			.right_entry (right_ent_i),
			.entry       (ent[i]),
			.gtx         (gtx[i]),
			.hit         (hits[i])
		);
	end

	sss_hit_tree u_hit_tree (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (phase_q == PH_RED),
		.hits    (hits),
		.any_hit (hit_any)
	);

	assign done     = done_q;
	assign member   = member_q;
	assign status   = status_q;
	assign set_size = size_q;

	// ---------------------------------------------------------------
	// assertions
	// ---------------------------------------------------------------

	// a result only follows the update phase
	a_done_after_upd: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(phase_q == PH_UPD))
		else $error("done without an update phase");

	// fill count never passes capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAP))
		else $error("entry count above capacity");

	// a refused insert leaves the set at capacity
	a_full_size: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == sss_pkg::ST_FULL) |-> (count_q == CNT_W'(CAP)))
		else $error("full status with room left");

	// a query, a refused insert or a failed delete never changes the count
	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_UPD && !ctl.ins && !ctl.del) |=> $stable(count_q))
		else $error("count changed without a shift");

endmodule

// File: hdl/sss_cell.sv
// ---------------------------------------------------------------------------
// sss_cell - one slot of the sorted register chain
// Holds one entry, compares it with the broadcast key, shifts with neighbors.
// ---------------------------------------------------------------------------
module sss_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  sss_pkg::cell_ctl_t         ctl,
	input  logic [sss_pkg::ID_W-1:0]   key,
	input  logic                       valid,
	input  logic                       left_gtx,
	input  logic [sss_pkg::ID_W-1:0]   left_entry,
	input  logic [sss_pkg::ID_W-1:0]   right_entry,
	output logic [sss_pkg::ID_W-1:0]   entry,
	output logic                       gtx,
	output logic                       hit
);

	logic [sss_pkg::ID_W-1:0] entry_q;
	logic                     hit_q;
	logic                     ge;
	logic                     eq;

	// empty slots count as larger than any key
	assign gtx = !valid || (entry_q > key);
	assign ge  = valid && (entry_q >= key);
	assign eq  = valid && (entry_q == key);

	always_ff @(posedge clk) begin
		if (ctl.ins && gtx) begin
			entry_q <= left_gtx ? left_entry : key;
		end else if (ctl.del && ge) begin
			entry_q <= right_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (ctl.cmp) begin
			hit_q <= eq;
		end
	end

	assign entry = entry_q;
	assign hit   = hit_q;

endmodule

// File: hdl/sss_hit_tree.sv
// ---------------------------------------------------------------------------
// sss_hit_tree - registered OR reduction of the per-cell match flags
// One register level of group ORs, then a narrow final OR.
// ---------------------------------------------------------------------------
module sss_hit_tree (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              load,
	input  logic [sss_pkg::SET_CAPACITY-1:0]  hits,
	output logic                              any_hit
);

	localparam int PAD_W = sss_pkg::NGRP * sss_pkg::GRP_SIZE;

	logic [PAD_W-1:0]         hits_pad;
	logic [sss_pkg::NGRP-1:0] grp_or;
	logic [sss_pkg::NGRP-1:0] grp_q;

	assign hits_pad = PAD_W'(hits);

	always_comb begin
		for (int g = 0; g < sss_pkg::NGRP; g++) begin
			grp_or[g] = |hits_pad[g*sss_pkg::GRP_SIZE +: sss_pkg::GRP_SIZE];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_q <= '0;
		end else if (load) begin
			grp_q <= grp_or;
		end
	end

	assign any_hit = |grp_q;

endmodule
